@@ hw/rtl/mbcoil_pkg.sv @@
package mbcoil_pkg;

  // Input item: one beat on the input channel.
  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  rx_byte;
    logic [7:0]  slave_addr;
    logic [15:0] start_address;
    logic [15:0] coil_count;
  } in_item_t;

  // Result item: one beat on the output channel.
  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] byte_value;
    logic [7:0] from_slave;
    logic       last;
  } out_item_t;

  // Input item kinds.
  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_BYTE  = 2'd1;
  localparam logic [1:0] FUNC_START = 2'd2;

  // Result kinds.
  localparam logic [2:0] KIND_REQ     = 3'd0;
  localparam logic [2:0] KIND_DATA    = 3'd1;
  localparam logic [2:0] KIND_CRC     = 3'd2;
  localparam logic [2:0] KIND_EXC     = 3'd3;
  localparam logic [2:0] KIND_TIMEOUT = 3'd4;

  // Configuration register indexes.
  localparam logic CFG_RESP_TIMEOUT = 1'b0;
  localparam logic CFG_GAP_TIMEOUT  = 1'b1;

  // Protocol constants.
  localparam logic [7:0]  FC_READ_COILS = 8'h01;
  localparam logic [7:0]  FC_EXC_FLAG   = 8'h80;
  localparam logic [7:0]  FC_READ_EXC   = FC_EXC_FLAG | FC_READ_COILS;
  localparam logic [15:0] TIMER_MAX     = 16'hFFFF;
  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam logic [15:0] CRC_POLY      = 16'hA001;

  // Offsets and fill counts as they travel between the modules.
  localparam int OFF_W  = 8;
  localparam int FILL_W = 9;

  // Source of the byte value of an emitted result.
  typedef enum logic [1:0] {
    SEL_CMD,
    SEL_RDATA,
    SEL_REQ
  } emit_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             tick;
    logic             start;
    logic             byte_op;
    logic             clear;
    logic             skip;
    logic             rd;
    logic [OFF_W-1:0] rd_off;
    logic             crc_init;
    logic             crc_upd;
    logic             crc_src_req;
    logic             lat_lo;
    logic             emit;
    logic [2:0]       emit_kind;
    emit_sel_t        emit_sel;
    logic [7:0]       emit_byte;
    logic             emit_last;
    logic [2:0]       req_idx;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic              waiting;
    logic              resp_ge;
    logic [FILL_W-1:0] fill;
    logic [7:0]        rdata;
    logic              rdata_is_target;
    logic              crc_match;
    logic              out_free;
  } dp_status_t;

  // One byte of the reflected CRC-16.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

@@ hw/rtl/mbcoil_dp.sv @@
module mbcoil_dp #(
  parameter int FRAME_DEPTH = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_fire,
  input  mbcoil_pkg::in_item_t  in_data,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [15:0]           cfg_wdata,
  input  mbcoil_pkg::dp_cmd_t   cmd,
  output mbcoil_pkg::dp_status_t status,
  output logic                  out_valid,
  input  logic                  out_ready,
  output mbcoil_pkg::out_item_t out_data
);
  import mbcoil_pkg::*;

  localparam int AW = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;
  localparam int FW = $clog2(FRAME_DEPTH + 1);
  localparam logic [AW:0] DEPTH_S = (AW + 1)'(FRAME_DEPTH);
  localparam logic [FW-1:0] DEPTH_F = FW'(FRAME_DEPTH);

  logic [15:0] resp_cfg;
  logic [15:0] gap_cfg;
  logic [15:0] resp_elapsed;
  logic [15:0] gap_elapsed;
  logic        waiting;
  logic [7:0]  target;
  in_item_t    item;
  logic [AW-1:0] head;
  logic [FW-1:0] fill;
  logic [7:0]  mem [FRAME_DEPTH];
  logic [7:0]  rdata;
  logic [15:0] crc;
  logic [7:0]  crc_lo;
  logic        gap_ge;
  logic [FW-1:0] fill_eff;
  logic [AW:0] wr_sum;
  logic [AW:0] rd_sum;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic [AW:0] head_inc;
  logic [7:0]  req_byte;
  logic [7:0]  crc_in;
  logic [7:0]  emit_val;
  logic        out_free;

  // Circular addressing of the frame store relative to the head.
  assign gap_ge   = gap_elapsed >= gap_cfg;
  assign fill_eff = gap_ge ? '0 : fill;
  assign wr_sum   = {1'b0, head} + (AW + 1)'(fill_eff);
  assign wr_addr  = (wr_sum >= DEPTH_S) ? AW'(wr_sum - DEPTH_S) : AW'(wr_sum);
  assign rd_sum   = {1'b0, head} + {1'b0, cmd.rd_off[AW-1:0]};
  assign rd_addr  = (rd_sum >= DEPTH_S) ? AW'(rd_sum - DEPTH_S) : AW'(rd_sum);
  assign head_inc = {1'b0, head} + (AW + 1)'(1);

  // Request frame bytes in send order.
  always_comb begin
    unique case (cmd.req_idx)
      3'd0: req_byte = item.slave_addr;
      3'd1: req_byte = FC_READ_COILS;
      3'd2: req_byte = item.start_address[15:8];
      3'd3: req_byte = item.start_address[7:0];
      3'd4: req_byte = item.coil_count[15:8];
      3'd5: req_byte = item.coil_count[7:0];
      3'd6: req_byte = crc[7:0];
      default: req_byte = crc[15:8];
    endcase
  end

  assign crc_in = cmd.crc_src_req ? req_byte : rdata;

  always_comb begin
    unique case (cmd.emit_sel)
      SEL_RDATA: emit_val = rdata;
      SEL_REQ:   emit_val = req_byte;
      default:   emit_val = cmd.emit_byte;
    endcase
  end

  assign out_free = !out_valid || out_ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      resp_cfg <= 16'd1000;
      gap_cfg  <= 16'd4;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RESP_TIMEOUT: resp_cfg <= cfg_wdata;
        default:          gap_cfg  <= cfg_wdata;
      endcase
    end
  end

  // Latched input item.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      item <= in_data;
    end
  end

  // Timers, transaction state and store bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      resp_elapsed <= '0;
      gap_elapsed  <= '0;
      waiting      <= 1'b0;
      target       <= '0;
      head         <= '0;
      fill         <= '0;
    end else begin
      if (cmd.tick) begin
        if (gap_elapsed != TIMER_MAX) begin
          gap_elapsed <= gap_elapsed + 16'd1;
        end
        if (waiting && resp_elapsed != TIMER_MAX) begin
          resp_elapsed <= resp_elapsed + 16'd1;
        end
      end
      if (cmd.start) begin
        target       <= item.slave_addr;
        waiting      <= 1'b1;
        resp_elapsed <= '0;
      end
      priority if (cmd.clear) begin
        fill    <= '0;
        waiting <= 1'b0;
      end else if (cmd.byte_op) begin
        gap_elapsed <= '0;
        if (fill_eff < DEPTH_F) begin
          fill <= fill_eff + FW'(1);
        end else begin
          fill <= fill_eff;
        end
      end else if (cmd.skip) begin
        head <= (head_inc >= DEPTH_S) ? '0 : AW'(head_inc);
        fill <= fill - FW'(1);
      end
    end
  end

  // Frame store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.byte_op && fill_eff < DEPTH_F) begin
      mem[wr_addr] <= item.rx_byte;
    end
    if (cmd.rd) begin
      rdata <= mem[rd_addr];
    end
  end

  // CRC accumulator and the latched low byte of a received CRC.
  always_ff @(posedge clk) begin
    if (cmd.crc_init) begin
      crc <= CRC_INIT;
    end else if (cmd.crc_upd) begin
      crc <= crc_byte(crc, crc_in);
    end
    if (cmd.lat_lo) begin
      crc_lo <= rdata;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data.kind       <= cmd.emit_kind;
      out_data.byte_value <= emit_val;
      out_data.from_slave <= (cmd.emit_sel == SEL_REQ) ? item.slave_addr : target;
      out_data.last       <= cmd.emit_last;
    end
  end

  assign status.waiting         = waiting;
  assign status.resp_ge         = resp_elapsed >= resp_cfg;
  assign status.fill            = FILL_W'(fill);
  assign status.rdata           = rdata;
  assign status.rdata_is_target = rdata == target;
  assign status.crc_match       = {rdata, crc_lo} == crc;
  assign status.out_free        = out_free;

  a_fill_bound: assert property (@(posedge clk) disable iff (rst) fill <= DEPTH_F)
    else $error("frame fill exceeds the store depth");
  a_head_bound: assert property (@(posedge clk) disable iff (rst) head < DEPTH_S[AW-1:0] ||
                                 FRAME_DEPTH == (1 << AW))
    else $error("frame head outside the store");
  a_emit_free: assert property (@(posedge clk) disable iff (rst) cmd.emit |-> out_free)
    else $error("result emitted over an untaken beat");
  a_skip_fill: assert property (@(posedge clk) disable iff (rst) cmd.skip |-> fill > FW'(1))
    else $error("alignment dropped the only stored byte");

endmodule

@@ hw/rtl/mbcoil_ctrl.sv @@
module mbcoil_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic [1:0]             in_func,
  output logic                   in_ready,
  input  mbcoil_pkg::dp_status_t status,
  output mbcoil_pkg::dp_cmd_t    cmd
);
  import mbcoil_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_TICK, S_TICK_CHK, S_REQ_INIT, S_REQ, S_BYTE, S_BYTE_CHK, S_TOUT,
    S_ALIGN, S_ALIGN_W, S_CHK, S_CHK1, S_CHK2, S_CRC, S_CRC_L, S_LO, S_HI,
    S_ERR, S_EXC, S_DAT
  } state_t;

  state_t      state;
  logic [2:0]  idx;
  logic [7:0]  code;
  logic [7:0]  cnt;
  logic [8:0]  ncrc;
  logic [8:0]  pos;
  logic [7:0]  dcount;
  logic [9:0]  need;
  logic [8:0]  pos_next;
  logic [8:0]  hi_off;
  logic [8:0]  dat_off;

  assign in_ready = state == S_IDLE;
  assign need     = 10'd5 + {2'b00, status.rdata};
  assign pos_next = pos + 9'd1;
  assign hi_off   = ncrc + 9'd1;
  assign dat_off  = 9'd4 + {1'b0, dcount};

  // Command decode for the current step.
  always_comb begin
    cmd = '0;
    cmd.emit_sel = SEL_CMD;
    unique case (state)
      S_TICK:     cmd.tick = 1'b1;
      S_REQ_INIT: begin
        cmd.start    = 1'b1;
        cmd.crc_init = 1'b1;
      end
      S_REQ: begin
        cmd.req_idx = idx;
        if (status.out_free) begin
          cmd.emit        = 1'b1;
          cmd.emit_kind   = KIND_REQ;
          cmd.emit_sel    = SEL_REQ;
          cmd.emit_last   = idx == 3'd7;
          cmd.crc_upd     = idx < 3'd6;
          cmd.crc_src_req = 1'b1;
        end
      end
      S_BYTE:     cmd.byte_op = 1'b1;
      S_TOUT, S_ERR: begin
        if (status.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = (state == S_TOUT) ? KIND_TIMEOUT : KIND_CRC;
          cmd.emit_last = 1'b1;
          cmd.clear     = 1'b1;
        end
      end
      S_EXC: begin
        if (status.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = KIND_EXC;
          cmd.emit_byte = cnt;
          cmd.emit_last = 1'b1;
          cmd.clear     = 1'b1;
        end
      end
      S_ALIGN: begin
        cmd.rd     = status.fill > FILL_W'(1);
        cmd.rd_off = '0;
      end
      S_ALIGN_W:  cmd.skip = !status.rdata_is_target;
      S_CHK: begin
        cmd.rd     = status.fill >= FILL_W'(4);
        cmd.rd_off = OFF_W'(1);
      end
      S_CHK1: begin
        cmd.rd     = 1'b1;
        cmd.rd_off = OFF_W'(2);
      end
      S_CRC: begin
        cmd.crc_init = 1'b1;
        cmd.rd       = 1'b1;
        cmd.rd_off   = '0;
      end
      S_CRC_L: begin
        cmd.crc_upd = 1'b1;
        cmd.rd      = 1'b1;
        cmd.rd_off  = (pos_next < ncrc) ? pos_next[OFF_W-1:0] : ncrc[OFF_W-1:0];
      end
      S_LO: begin
        cmd.lat_lo = 1'b1;
        cmd.rd     = 1'b1;
        cmd.rd_off = hi_off[OFF_W-1:0];
      end
      S_HI: begin
        cmd.clear  = status.crc_match && code == FC_READ_COILS && cnt == 8'd0;
        cmd.rd     = 1'b1;
        cmd.rd_off = OFF_W'(3);
      end
      S_DAT: begin
        if (status.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = KIND_DATA;
          cmd.emit_sel  = SEL_RDATA;
          cmd.emit_last = dcount == cnt - 8'd1;
          cmd.clear     = cmd.emit_last;
          cmd.rd        = !cmd.emit_last;
          cmd.rd_off    = dat_off[OFF_W-1:0];
        end
      end
      default: ;
    endcase
  end

  // Sequencer state and its counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            unique case (in_func)
              FUNC_TICK:  state <= S_TICK;
              FUNC_BYTE:  state <= S_BYTE;
              FUNC_START: state <= S_REQ_INIT;
              default:    state <= S_IDLE;
            endcase
          end
        end
        S_TICK:     state <= S_TICK_CHK;
        S_TICK_CHK: state <= (status.waiting && status.resp_ge) ? S_TOUT : S_IDLE;
        S_REQ_INIT: begin
          idx   <= '0;
          state <= S_REQ;
        end
        S_REQ: begin
          if (status.out_free) begin
            idx <= idx + 3'd1;
            if (idx == 3'd7) begin
              state <= S_IDLE;
            end
          end
        end
        S_BYTE:     state <= S_BYTE_CHK;
        S_BYTE_CHK: begin
          priority if (!status.waiting) begin
            state <= S_IDLE;
          end else if (status.resp_ge) begin
            state <= S_TOUT;
          end else begin
            state <= S_ALIGN;
          end
        end
        S_TOUT, S_ERR, S_EXC: begin
          if (status.out_free) begin
            state <= S_IDLE;
          end
        end
        S_ALIGN:    state <= (status.fill > FILL_W'(1)) ? S_ALIGN_W : S_CHK;
        S_ALIGN_W:  state <= status.rdata_is_target ? S_CHK : S_ALIGN;
        S_CHK:      state <= (status.fill >= FILL_W'(4)) ? S_CHK1 : S_IDLE;
        S_CHK1: begin
          code  <= status.rdata;
          state <= S_CHK2;
        end
        S_CHK2: begin
          cnt <= status.rdata;
          priority if (code == FC_READ_COILS) begin
            ncrc  <= 9'd3 + {1'b0, status.rdata};
            state <= ({1'b0, status.fill} < need) ? S_IDLE : S_CRC;
          end else if (code == FC_READ_EXC) begin
            ncrc  <= 9'd3;
            state <= (status.fill < FILL_W'(5)) ? S_IDLE : S_CRC;
          end else begin
            state <= S_IDLE;
          end
        end
        S_CRC: begin
          pos   <= '0;
          state <= S_CRC_L;
        end
        S_CRC_L: begin
          pos <= pos_next;
          if (pos_next >= ncrc) begin
            state <= S_LO;
          end
        end
        S_LO:       state <= S_HI;
        S_HI: begin
          dcount <= '0;
          priority if (!status.crc_match) begin
            state <= S_ERR;
          end else if (code == FC_READ_EXC) begin
            state <= S_EXC;
          end else if (cnt == 8'd0) begin
            state <= S_IDLE;
          end else begin
            state <= S_DAT;
          end
        end
        S_DAT: begin
          if (status.out_free) begin
            dcount <= dcount + 8'd1;
            if (dcount == cnt - 8'd1) begin
              state <= S_IDLE;
            end
          end
        end
        default:    state <= S_IDLE;
      endcase
    end
  end

  a_emit_busy: assert property (@(posedge clk) disable iff (rst) cmd.emit |-> !in_ready)
    else $error("result emitted while idle");
  a_tout_wait: assert property (@(posedge clk) disable iff (rst)
                                (state == S_TOUT) |-> status.waiting)
    else $error("timeout raised with no transaction open");
  a_dat_count: assert property (@(posedge clk) disable iff (rst)
                                (state == S_DAT) |-> dcount < cnt)
    else $error("data walk ran past the byte count");

endmodule

@@ hw/rtl/modbus_rtu_coil_read_master.sv @@
// Per item: a start emits 8 request beats; a byte with a transaction open passes the timeout and
// frame checks, dropping leading bytes that are not the target slave; a completing byte walks
// the CRC over 3 + n stored bytes and then emits one result beat per data byte.
// Throughput: one item at a time; the CRC walk over the stored frame, one byte a cycle on the
// frame store read port, and the output handshake (one beat a cycle unless out_ready holds it back) set the rate.
// Reset: synchronous; configuration returns to 1000 and 4 ticks, no transaction is open and
// the frame store is empty without a clearing pass.
module modbus_rtu_coil_read_master #(
  parameter int FRAME_DEPTH = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  mbcoil_pkg::in_item_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output mbcoil_pkg::out_item_t out_data,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [15:0]           cfg_wdata
);
  import mbcoil_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       in_fire;

  // An input beat moves when both sides agree.
  assign in_fire = in_valid && in_ready;

  mbcoil_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_func  (in_data.func),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  mbcoil_dp #(
    .FRAME_DEPTH (FRAME_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (in_fire),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
